### rtl/core/h2v_pkg.sv
package h2v_pkg;

    // angle and datapath widths
    localparam int VEC_W   = 37;  // vectoring x/y, position deltas shifted up by 16
    localparam int ROT_W   = 35;  // rotation x/y, speed times gain with 16 fraction bits
    localparam int ANG_W   = 30;  // internal angle, degrees with 20 fraction bits
    localparam int MAX_STAGES = 24;

    // compass constants, degrees with 7 fraction bits
    localparam int TURN_Q7 = 46080;
    localparam int DEG90_Q7  = 11520;
    localparam int DEG180_Q7 = 23040;
    localparam int DEG270_Q7 = 34560;

    // cordic gain in Q30
    localparam longint GAIN_Q30 = 652032874;

    // arctangent of 2^-i, degrees with 20 fraction bits
    localparam longint ATAN_TAB [0:MAX_STAGES-1] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    // vectoring cell datapath
    typedef struct packed {
        logic signed [VEC_W-1:0] u;
        logic signed [VEC_W-1:0] v;
        logic signed [ANG_W-1:0] z;
    } vec_data_t;

    // request fields riding along the vectoring chain
    typedef struct packed {
        logic               mode;
        logic [15:0]        speed;
        logic signed [17:0] offset;
        logic signed [18:0] hsum;
        logic               special;
        logic [15:0]        spec_val;
        logic               turned;
    } vec_side_t;

    // rotation cell datapath
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } rot_data_t;

    // fields riding along the rotation chain
    typedef struct packed {
        logic [15:0] heading;
        logic        flip;
    } rot_side_t;

endpackage

### rtl/core/h2v_vec_cell.sv
module h2v_vec_cell #(
    parameter int STAGE = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  h2v_pkg::vec_data_t    in_data,
    input  h2v_pkg::vec_side_t    in_side,
    output logic                  out_valid,
    output h2v_pkg::vec_data_t    out_data,
    output h2v_pkg::vec_side_t    out_side
);

    localparam logic signed [h2v_pkg::ANG_W-1:0] ATAN =
        h2v_pkg::ANG_W'(h2v_pkg::ATAN_TAB[STAGE]);

    logic                 valid_reg;
    h2v_pkg::vec_data_t   data_reg;
    h2v_pkg::vec_data_t   data_next;
    h2v_pkg::vec_side_t   side_reg;

    // one micro-rotation driving v toward zero
    always_comb
    begin
        if (in_data.v > 0)
        begin
            data_next.u = in_data.u + (in_data.v >>> STAGE);
            data_next.v = in_data.v - (in_data.u >>> STAGE);
            data_next.z = in_data.z + ATAN;
        end
        else
        begin
            data_next.u = in_data.u - (in_data.v >>> STAGE);
            data_next.v = in_data.v + (in_data.u >>> STAGE);
            data_next.z = in_data.z - ATAN;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

### rtl/core/h2v_rot_cell.sv
module h2v_rot_cell #(
    parameter int STAGE = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  h2v_pkg::rot_data_t    in_data,
    input  h2v_pkg::rot_side_t    in_side,
    output logic                  out_valid,
    output h2v_pkg::rot_data_t    out_data,
    output h2v_pkg::rot_side_t    out_side
);

    localparam logic signed [h2v_pkg::ANG_W-1:0] ATAN =
        h2v_pkg::ANG_W'(h2v_pkg::ATAN_TAB[STAGE]);

    logic                 valid_reg;
    h2v_pkg::rot_data_t   data_reg;
    h2v_pkg::rot_data_t   data_next;
    h2v_pkg::rot_side_t   side_reg;

    // one micro-rotation driving z toward zero
    always_comb
    begin
        if (in_data.z >= 0)
        begin
            data_next.x = in_data.x - (in_data.y >>> STAGE);
            data_next.y = in_data.y + (in_data.x >>> STAGE);
            data_next.z = in_data.z - ATAN;
        end
        else
        begin
            data_next.x = in_data.x + (in_data.y >>> STAGE);
            data_next.y = in_data.y - (in_data.x >>> STAGE);
            data_next.z = in_data.z + ATAN;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

### rtl/core/heading_to_velocity.sv
// Turns a launch request into a velocity vector. One transaction is accepted per clock
// while the output side keeps up; each result passes through two chains of CORDIC cells
// (one finds the bearing to the target, one rotates the speed vector) plus input, wrap,
// gain multiply and output registers. The whole pipeline holds while a result waits at
// the output, so throughput is one per cycle when the output is always ready.
module heading_to_velocity #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // speed, heading_deg, offset_deg, origin_x, origin_y, target_x, target_y,
    // target_shift_x, target_shift_y
    input  logic [151:0] s_axis_tdata,
    // mode
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vel_x, vel_y, final_heading
    output logic [47:0]  m_axis_tdata
);

    localparam int N = (CORDIC_STAGES < h2v_pkg::MAX_STAGES) ? CORDIC_STAGES
                                                             : h2v_pkg::MAX_STAGES;
    localparam int VW = h2v_pkg::VEC_W;
    localparam int RW = h2v_pkg::ROT_W;
    localparam int AW = h2v_pkg::ANG_W;

    logic adv;

    // input register
    logic               in_valid_reg;
    logic               mode_reg;
    logic [15:0]        speed_reg;
    logic signed [17:0] offset_reg;
    logic signed [18:0] hsum_reg;
    logic signed [17:0] dx_reg;
    logic signed [17:0] dy_reg;

    logic signed [17:0] dx_next;
    logic signed [17:0] dy_next;
    logic signed [18:0] hsum_next;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // target deltas and heading sum
    always_comb
    begin
        dx_next = 18'($signed(s_axis_tdata[99:84])) + 18'($signed(s_axis_tdata[131:116]))
                - 18'($signed(s_axis_tdata[67:52]));
        dy_next = 18'($signed(s_axis_tdata[115:100])) + 18'($signed(s_axis_tdata[147:132]))
                - 18'($signed(s_axis_tdata[83:68]));
        hsum_next = 19'($signed(s_axis_tdata[33:16])) + 19'($signed(s_axis_tdata[51:34]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg   <= s_axis_tuser[0];
            speed_reg  <= s_axis_tdata[15:0];
            offset_reg <= $signed(s_axis_tdata[51:34]);
            hsum_reg   <= hsum_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
        end
    end

    // vectoring chain setup: axis cases and half-plane turn
    h2v_pkg::vec_data_t vec_d [0:N];
    h2v_pkg::vec_side_t vec_s [0:N];
    logic               vec_v [0:N];

    h2v_pkg::vec_data_t vec_d0;
    h2v_pkg::vec_side_t vec_s0;

    logic signed [VW-1:0] u0;
    logic signed [VW-1:0] v0;

    always_comb
    begin
        u0 = -(VW'(dy_reg) <<< 16);
        v0 = VW'(dx_reg) <<< 16;
        vec_s0.mode    = mode_reg;
        vec_s0.speed   = speed_reg;
        vec_s0.offset  = offset_reg;
        vec_s0.hsum    = hsum_reg;
        vec_s0.special = (dx_reg == 0) || (dy_reg == 0);
        if (dx_reg == 0)
            vec_s0.spec_val = (dy_reg <= 0) ? 16'd0 : 16'(h2v_pkg::DEG180_Q7);
        else
            vec_s0.spec_val = (dx_reg > 0) ? 16'(h2v_pkg::DEG90_Q7)
                                           : 16'(h2v_pkg::DEG270_Q7);
        vec_s0.turned = u0 < 0;
        vec_d0.u = (u0 < 0) ? -u0 : u0;
        vec_d0.v = (u0 < 0) ? -v0 : v0;
        vec_d0.z = '0;
    end
    assign vec_d[0] = vec_d0;
    assign vec_s[0] = vec_s0;
    assign vec_v[0] = in_valid_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        h2v_vec_cell #(.STAGE(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (vec_v[i]),
            .in_data   (vec_d[i]),
            .in_side   (vec_s[i]),
            .out_valid (vec_v[i+1]),
            .out_data  (vec_d[i+1]),
            .out_side  (vec_s[i+1])
        );
    end

    // bearing or heading plus offset, wrapped into one turn
    logic signed [16:0] zq;
    logic signed [20:0] bear;
    logic signed [20:0] tot;
    logic signed [20:0] cand;
    logic [15:0]        wrap_h;

    always_comb
    begin
        zq = 17'((vec_d[N].z + AW'(4096)) >>> 13);
        if (vec_s[N].special)
            bear = 21'($signed({1'b0, vec_s[N].spec_val}));
        else if (vec_s[N].turned)
            bear = 21'(zq) + 21'(h2v_pkg::DEG180_Q7);
        else
            bear = 21'(zq);
        tot = vec_s[N].mode ? bear + 21'(vec_s[N].offset) : 21'(vec_s[N].hsum);
        wrap_h = '0;
        cand = '0;
        for (int k = -4; k <= 3; k++)
        begin
            cand = tot - 21'(k * h2v_pkg::TURN_Q7);
            if (cand >= 0 && cand < 21'(h2v_pkg::TURN_Q7))
                wrap_h = cand[15:0];
        end
    end

    logic        w_valid_reg;
    logic [15:0] w_h_reg;
    logic [15:0] w_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_valid_reg <= 1'b0;
        else if (adv)
            w_valid_reg <= vec_v[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_h_reg     <= wrap_h;
            w_speed_reg <= vec_s[N].speed;
        end
    end

    // quadrant fold and gain multiply
    logic signed [16:0] hs;
    logic               flip_next;
    logic [45:0]        prod;

    always_comb
    begin
        hs = $signed({1'b0, w_h_reg});
        if (hs > 17'(h2v_pkg::DEG180_Q7))
            hs = hs - 17'(h2v_pkg::TURN_Q7);
        flip_next = 1'b0;
        if (hs > 17'(h2v_pkg::DEG90_Q7))
        begin
            hs = hs - 17'(h2v_pkg::DEG180_Q7);
            flip_next = 1'b1;
        end
        else if (hs < -17'(h2v_pkg::DEG90_Q7))
        begin
            hs = hs + 17'(h2v_pkg::DEG180_Q7);
            flip_next = 1'b1;
        end
        prod = 46'(w_speed_reg) * 46'(h2v_pkg::GAIN_Q30);
    end

    h2v_pkg::rot_data_t rot_d [0:N];
    h2v_pkg::rot_side_t rot_s [0:N];
    logic               rot_v [0:N];
    logic               m_valid_reg;
    h2v_pkg::rot_data_t rot_d0_reg;
    h2v_pkg::rot_side_t rot_s0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= w_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_d0_reg.x       <= RW'(prod[45:14]);
            rot_d0_reg.y       <= '0;
            rot_d0_reg.z       <= AW'(hs) <<< 13;
            rot_s0_reg.heading <= w_h_reg;
            rot_s0_reg.flip    <= flip_next;
        end
    end
    assign rot_d[0] = rot_d0_reg;
    assign rot_s[0] = rot_s0_reg;
    assign rot_v[0] = m_valid_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        h2v_rot_cell #(.STAGE(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (rot_v[i]),
            .in_data   (rot_d[i]),
            .in_side   (rot_s[i]),
            .out_valid (rot_v[i+1]),
            .out_data  (rot_d[i+1]),
            .out_side  (rot_s[i+1])
        );
    end

    // drop the 16 fraction bits with rounding and saturate
    function automatic logic [15:0] sat16(input logic signed [RW:0] v);
        logic signed [RW:0]    r;
        logic signed [RW-16:0] q;
        r = v + (RW+1)'(32768);
        q = r[RW:16];
        if (q > 32767)
            return 16'h7fff;
        else if (q < -32768)
            return 16'h8000;
        else
            return q[15:0];
    endfunction

    logic signed [RW:0] fx;
    logic signed [RW:0] fy;

    always_comb
    begin
        fx = (RW+1)'(rot_d[N].x);
        fy = (RW+1)'(rot_d[N].y);
        if (rot_s[N].flip)
        begin
            fx = -fx;
            fy = -fy;
        end
    end

    // output register
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= rot_v[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= {rot_s[N].heading, sat16(-fx), sat16(fy)};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### verif/heading_to_velocity_test.sv
module heading_to_velocity_test;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES * 2 + 4;
    localparam int RANDOM_ITEMS = 1330;

    typedef enum logic { AIM_HEADING = 1'b0, AIM_TARGET = 1'b1 } aim_mode_t;

    typedef struct {
        aim_mode_t          mode;
        logic [15:0]        speed;
        logic signed [17:0] heading_deg;
        logic signed [17:0] offset_deg;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
    } launch_t;

    typedef struct {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [15:0]        heading;
    } velocity_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;

    launch_t   launch_queue[$];
    velocity_t expected_velocities[$];
    int        error_count;
    int        cycle_count;
    int        hold_cycles;

    heading_to_velocity #(
        .CORDIC_STAGES(STAGES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // compass bearing to the shifted target, degrees with 7 fraction bits
    function automatic longint bearing_to_target(longint dx, longint dy);
        longint u;
        longint v;
        longint z;
        longint base;
        longint su;
        longint sv;
        z = 0;
        base = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (dx == 0)
            return (dy < 0) ? 0 : h2v_pkg::DEG180_Q7;
        if (dy == 0)
            return (dx > 0) ? h2v_pkg::DEG90_Q7 : h2v_pkg::DEG270_Q7;
        u = -dy * 65536;
        v = dx * 65536;
        if (u < 0)
        begin
            u = -u;
            v = -v;
            base = h2v_pkg::DEG180_Q7;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            su = u >>> i;
            sv = v >>> i;
            if (v > 0)
            begin
                u += sv;
                v -= su;
                z += h2v_pkg::ATAN_TAB[i];
            end
            else
            begin
                u -= sv;
                v += su;
                z -= h2v_pkg::ATAN_TAB[i];
            end
        end
        return base + ((z + 4096) >>> 13);
    endfunction

    function automatic logic [15:0] round_saturate(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // velocity vector for one launch request
    function automatic velocity_t launch_velocity(launch_t req);
        velocity_t res;
        longint    h;
        longint    a;
        longint    x;
        longint    y;
        longint    sx;
        longint    sy;
        longint    dx;
        longint    dy;
        logic      flip;
        flip = 1'b0;
        if (req.mode == AIM_TARGET)
        begin
            dx = longint'(req.target_x) + longint'(req.shift_x) - longint'(req.origin_x);
            dy = longint'(req.target_y) + longint'(req.shift_y) - longint'(req.origin_y);
            h = bearing_to_target(dx, dy) + longint'(req.offset_deg);
        end
        else
            h = longint'(req.heading_deg) + longint'(req.offset_deg);
        h = h % h2v_pkg::TURN_Q7;
        if (h < 0)
            h += h2v_pkg::TURN_Q7;
        // map into (-180,180] then fold into [-90,90]
        a = h * 8192;
        if (a > (longint'(180) << 20))
            a -= longint'(360) << 20;
        if (a > (longint'(90) << 20))
        begin
            a -= longint'(180) << 20;
            flip = 1'b1;
        end
        else if (a < -(longint'(90) << 20))
        begin
            a += longint'(180) << 20;
            flip = 1'b1;
        end
        x = (longint'(req.speed) * h2v_pkg::GAIN_Q30) >>> 14;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            sx = x >>> i;
            sy = y >>> i;
            if (a >= 0)
            begin
                x -= sy;
                y += sx;
                a -= h2v_pkg::ATAN_TAB[i];
            end
            else
            begin
                x += sy;
                y -= sx;
                a += h2v_pkg::ATAN_TAB[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        res.vel_x = round_saturate(y);
        res.vel_y = round_saturate(-x);
        res.heading = h[15:0];
        return res;
    endfunction

    function automatic logic [151:0] pack_launch(launch_t req);
        return {4'b0, req.shift_y, req.shift_x, req.target_y, req.target_x,
                req.origin_y, req.origin_x, req.offset_deg, req.heading_deg, req.speed};
    endfunction

    function automatic launch_t unpack_launch(logic [151:0] d, logic [0:0] u);
        launch_t req;
        req.mode        = aim_mode_t'(u[0]);
        req.speed       = d[15:0];
        req.heading_deg = d[33:16];
        req.offset_deg  = d[51:34];
        req.origin_x    = d[67:52];
        req.origin_y    = d[83:68];
        req.target_x    = d[99:84];
        req.target_y    = d[115:100];
        req.shift_x     = d[131:116];
        req.shift_y     = d[147:132];
        return req;
    endfunction

    function automatic logic signed [17:0] any_angle();
        return 18'(int'($urandom_range(184319)) - 92160);
    endfunction

    function automatic logic signed [15:0] any_position();
        return 16'($urandom);
    endfunction

    function automatic launch_t random_launch();
        launch_t req;
        int      pick;
        req.mode        = aim_mode_t'($urandom_range(1));
        req.speed       = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
        req.heading_deg = any_angle();
        req.offset_deg  = ($urandom_range(3) == 0) ? 18'sd0 : any_angle();
        req.origin_x    = any_position();
        req.origin_y    = any_position();
        req.target_x    = any_position();
        req.target_y    = any_position();
        req.shift_x     = any_position();
        req.shift_y     = any_position();
        pick = $urandom_range(9);
        // small deltas, points on an axis and coincident points
        if (pick < 3)
        begin
            req.target_x = req.origin_x + 16'(int'($urandom_range(64)) - 32);
            req.target_y = req.origin_y + 16'(int'($urandom_range(64)) - 32);
            req.shift_x  = 16'(int'($urandom_range(8)) - 4);
            req.shift_y  = 16'(int'($urandom_range(8)) - 4);
        end
        else if (pick == 3)
        begin
            req.shift_x  = 16'sd0;
            req.target_x = req.origin_x;
        end
        else if (pick == 4)
        begin
            req.shift_y  = 16'sd0;
            req.target_y = req.origin_y;
        end
        else if (pick == 5)
        begin
            req.shift_x  = 16'sd0;
            req.shift_y  = 16'sd0;
            req.target_x = req.origin_x;
            req.target_y = req.origin_y;
        end
        return req;
    endfunction

    function automatic launch_t directed_launch(aim_mode_t m, int spd, int hd, int off,
                                                int ox, int oy, int tx, int ty,
                                                int shx, int shy);
        launch_t req;
        req.mode        = m;
        req.speed       = 16'(spd);
        req.heading_deg = 18'(hd);
        req.offset_deg  = 18'(off);
        req.origin_x    = 16'(ox);
        req.origin_y    = 16'(oy);
        req.target_x    = 16'(tx);
        req.target_y    = 16'(ty);
        req.shift_x     = 16'(shx);
        req.shift_y     = 16'(shy);
        return req;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    function automatic logic idle_now();
        // no idling in this window
        if (cycle_count > 500 && cycle_count < 1000)
            return 1'b0;
        return $urandom_range(99) < 26;
    endfunction

    // driver: offer the next pending launch request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (launch_queue.size() > 0 && !idle_now())
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pack_launch(launch_queue[0]);
                s_axis_tuser  <= launch_queue[0].mode;
                launch_queue.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // record the expected velocity for each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_velocities.push_back(
                launch_velocity(unpack_launch(s_axis_tdata, s_axis_tuser)));
    end

    // receiver ready, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            cycle_count   <= 0;
            hold_cycles   <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == 1500)
                hold_cycles <= 300;
            else if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            m_axis_tready <= (hold_cycles == 0 && cycle_count != 1500) && !idle_now();
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_velocities.size() == 0)
            begin
                $display("unexpected result transaction %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                if (m_axis_tdata[15:0] !== expected_velocities[0].vel_x)
                    report_mismatch("vel_x", $signed(m_axis_tdata[15:0]),
                                    expected_velocities[0].vel_x);
                if (m_axis_tdata[31:16] !== expected_velocities[0].vel_y)
                    report_mismatch("vel_y", $signed(m_axis_tdata[31:16]),
                                    expected_velocities[0].vel_y);
                if (m_axis_tdata[47:32] !== expected_velocities[0].heading)
                    report_mismatch("final_heading", m_axis_tdata[47:32],
                                    expected_velocities[0].heading);
                expected_velocities.pop_front();
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        error_count   = 0;
        rst_n = 1'b0;
        // extremes, both modes and the bearing special cases
        launch_queue.push_back(directed_launch(AIM_HEADING, 256, 0, 0, 0, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_HEADING, 65535, 11520, 0, 0, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_HEADING, 65535, 92159, 92159,
                                               0, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_HEADING, 65535, -92160, -92160,
                                               -1, -1, -1, -1, -1, -1));
        launch_queue.push_back(directed_launch(AIM_HEADING, 0, 23040, 0, 0, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_HEADING, 1000, 46079, 1, 0, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_HEADING, 1000, -1, 0, 0, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_HEADING, 40000, 34560, 0, 0, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 10, 10, 10, 10, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 0, 100, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 0, 0, 0, 100, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 0, 0, 100, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 100, 0, 0, 0, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 0, 0, 30, 40, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 0, 0, -30, 40, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 5000, 0, 0, 0, 0, -30, -40, 0, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 65535, 12345, 92159,
                                               -32768, -32768, 32767, 32767, 32767, 32767));
        launch_queue.push_back(directed_launch(AIM_TARGET, 65535, 0, -92160,
                                               32767, 32767, -32768, -32768, -32768, -32768));
        launch_queue.push_back(directed_launch(AIM_TARGET, 700, 0, 11520, 5, 5, 0, 5, 5, 0));
        launch_queue.push_back(directed_launch(AIM_TARGET, 0, 0, 100, 0, 0, 1, -1, 0, 0));
        for (int i = 0; i < RANDOM_ITEMS; i++)
            launch_queue.push_back(random_launch());
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (launch_queue.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_velocities.size() > 0)
            @(posedge clk);
        repeat (LATENCY * 2) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // timeout
    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
